### rtl/tmd_pkg.sv
package tmd_pkg;

  localparam int MAX_IMAGE_SIDE = 4096;
  localparam int MAX_TILES_SIDE = 256;

  localparam int SIDE_W    = 13;
  localparam int TILE_W    = 9;
  localparam int POS_W     = 12;
  localparam int IDX_W     = 8;
  localparam int PIX_W     = 8;
  localparam int SUM_W     = 32;
  localparam int CNT_W     = 25;
  localparam int MEAN_W    = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 13;
  localparam int NUM_CH    = 3;
  localparam int FRAC_W    = 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam int DIV_STEPS = MEAN_W;
  localparam int DIV_CNT_W = 4;
  localparam int DVD_W     = SUM_W + FRAC_W + 1;

  localparam int AX_STEPS = POS_W;
  localparam int AX_CNT_W = 4;

  typedef enum logic [1:0] {
    REG_IMAGE_ROWS,
    REG_IMAGE_COLS,
    REG_TILE_ROWS,
    REG_TILE_COLS
  } reg_idx_t;

  typedef logic [NUM_CH-1:0][SUM_W-1:0] sums_t;

  typedef struct packed {
    logic [IDX_W-1:0] tile_row;
    logic [IDX_W-1:0] tile_col;
    sums_t            sums;
    logic [CNT_W-1:0] count;
    logic             last;
  } tile_job_t;

  typedef struct packed {
    logic start;
    logic reinit;
    logic step;
  } ax_ctrl_t;

  typedef struct packed {
    logic             busy;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
  } ax_stat_t;

  typedef enum logic [2:0] {
    F_START,
    F_WAIT,
    F_IDLE,
    F_RMW0,
    F_RMW1
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_t;

  function automatic logic [SIDE_W-1:0] side_of(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] res;
    res = v;
    if (v < SIDE_W'(2)) res = SIDE_W'(2);
    if (v > SIDE_W'(MAX_IMAGE_SIDE)) res = SIDE_W'(MAX_IMAGE_SIDE);
    return res;
  endfunction

  function automatic logic [TILE_W-1:0] tiles_of(input logic [TILE_W-1:0] t,
                                                 input logic [SIDE_W-1:0] side);
    logic [SIDE_W-1:0] hi;
    logic [TILE_W-1:0] res;
    hi = side - SIDE_W'(1);
    if (hi > SIDE_W'(MAX_TILES_SIDE)) hi = SIDE_W'(MAX_TILES_SIDE);
    res = t;
    if ({{(SIDE_W-TILE_W){1'b0}}, t} > hi) res = TILE_W'(hi);
    if (t < TILE_W'(1)) res = TILE_W'(1);
    return res;
  endfunction

  // boundary index from quotient and remainder, ties to even
  function automatic logic [POS_W-1:0] bnd(input logic [SIDE_W-1:0] q,
                                           input logic [TILE_W-1:0] r,
                                           input logic [TILE_W-1:0] t);
    logic [TILE_W:0] r2;
    logic            up;
    r2 = {r, 1'b0};
    up = (r2 > {1'b0, t}) || ((r2 == {1'b0, t}) && q[0]);
    return POS_W'(q - SIDE_W'(1) + SIDE_W'(up));
  endfunction

endpackage

### rtl/tmd_axis.sv
module tmd_axis import tmd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [POS_W-1:0]  side_m1,
  input  logic [TILE_W-1:0] tiles,
  input  ax_ctrl_t          ctl,
  output ax_stat_t          st
);

  logic                run;
  logic                init_pend;
  logic [AX_CNT_W-1:0] iter;
  logic [POS_W-1:0]    dq;
  logic [TILE_W-1:0]   dr;
  logic [TILE_W:0]     trial;
  logic                fits;
  logic [SIDE_W-1:0]   q;
  logic [TILE_W-1:0]   r;
  logic [POS_W-1:0]    lo;
  logic [POS_W-1:0]    hi;
  logic [SIDE_W-1:0]   q_init;
  logic [TILE_W:0]     r_sum;
  logic [SIDE_W-1:0]   q_sum;
  logic                wrap;
  logic [TILE_W-1:0]   r_step;
  logic [SIDE_W-1:0]   q_step;

  // restoring division of (side-1) by tiles, one quotient bit a cycle
  assign trial = {dr, dq[POS_W-1]};
  assign fits  = trial >= {1'b0, tiles};

  assign q_init = SIDE_W'(dq) + SIDE_W'(1);
  assign r_sum  = {1'b0, r} + {1'b0, dr};
  assign q_sum  = q + SIDE_W'(dq);
  assign wrap   = r_sum >= {1'b0, tiles};
  assign r_step = wrap ? TILE_W'(r_sum - {1'b0, tiles}) : TILE_W'(r_sum);
  assign q_step = q_sum + SIDE_W'(wrap);

  always_ff @(posedge clk) begin
    if (rst) begin
      run       <= 1'b0;
      init_pend <= 1'b0;
      iter      <= '0;
    end else if (ctl.start) begin
      run       <= 1'b1;
      init_pend <= 1'b0;
      iter      <= '0;
      dq        <= side_m1;
      dr        <= '0;
    end else if (run) begin
      dq   <= {dq[POS_W-2:0], fits};
      dr   <= fits ? TILE_W'(trial - {1'b0, tiles}) : TILE_W'(trial);
      iter <= iter + AX_CNT_W'(1);
      if (iter == AX_CNT_W'(AX_STEPS - 1)) begin
        run       <= 1'b0;
        init_pend <= 1'b1;
      end
    end else if (init_pend || ctl.reinit) begin
      init_pend <= 1'b0;
      q         <= q_init;
      r         <= dr;
      lo        <= '0;
      hi        <= bnd(q_init, dr, tiles);
    end else if (ctl.step) begin
      lo <= hi;
      q  <= q_step;
      r  <= r_step;
      hi <= bnd(q_step, r_step, tiles);
    end
  end

  assign st.busy = run | init_pend;
  assign st.lo   = lo;
  assign st.hi   = hi;

endmodule

### rtl/tmd_front.sv
module tmd_front import tmd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 pix_valid,
  output logic                 pix_stall,
  input  logic [PIX_W-1:0]     red,
  input  logic [PIX_W-1:0]     green,
  input  logic [PIX_W-1:0]     blue,
  input  logic                 q_full,
  output logic                 push,
  output tile_job_t            job
);

  logic [SIDE_W-1:0] image_rows;
  logic [SIDE_W-1:0] image_cols;
  logic [TILE_W-1:0] tile_rows;
  logic [TILE_W-1:0] tile_cols;
  logic [SIDE_W-1:0] sr;
  logic [SIDE_W-1:0] sc;
  logic [TILE_W-1:0] tr;
  logic [TILE_W-1:0] tc;

  front_state_t state, state_next;

  ax_ctrl_t row_ctl, col_ctl;
  ax_stat_t row_st, col_st;

  logic [POS_W-1:0]  row_counter;
  logic [POS_W-1:0]  col_counter;
  logic [IDX_W-1:0]  ti;
  logic [IDX_W-1:0]  tj;
  logic              sel;
  logic [TILE_W-1:0] fill0;
  logic [TILE_W-1:0] fill1;
  logic [TILE_W-1:0] fill0_next;
  logic [TILE_W-1:0] fill1_next;
  logic [NUM_CH-1:0][PIX_W-1:0] px;
  logic              row_sh_q;
  logic              col_sh_q;
  logic              close_q;

  logic [2*NUM_CH*SUM_W-1:0] band_mem [MAX_TILES_SIDE];
  logic [2*NUM_CH*SUM_W-1:0] rd_word;
  logic [2*NUM_CH*SUM_W-1:0] wr_word;
  logic              rd_v0;
  logic              rd_v1;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic              mem_we;

  logic              accept;
  logic              row_edge;
  logic              col_edge;
  logic [TILE_W-1:0] ti_inc;
  logic [TILE_W-1:0] tj_inc;
  logic              row_share;
  logic              col_share;
  logic              col_end;
  logic              img_end;
  logic              finish;
  sums_t             bank0;
  sums_t             bank1;
  sums_t             cur;
  sums_t             nxt;
  sums_t             new_cur;
  sums_t             new_nxt;
  logic [SIDE_W-1:0] h;
  logic [SIDE_W-1:0] w;

  assign sr = side_of(image_rows);
  assign sc = side_of(image_cols);
  assign tr = tiles_of(tile_rows, sr);
  assign tc = tiles_of(tile_cols, sc);

  tmd_axis u_row_axis (
    .clk     (clk),
    .rst     (rst),
    .side_m1 (POS_W'(sr - SIDE_W'(1))),
    .tiles   (tr),
    .ctl     (row_ctl),
    .st      (row_st)
  );

  tmd_axis u_col_axis (
    .clk     (clk),
    .rst     (rst),
    .side_m1 (POS_W'(sc - SIDE_W'(1))),
    .tiles   (tc),
    .ctl     (col_ctl),
    .st      (col_st)
  );

  assign accept    = pix_valid && !pix_stall;
  assign row_edge  = row_counter == row_st.hi;
  assign col_edge  = col_counter == col_st.hi;
  assign ti_inc    = {1'b0, ti} + TILE_W'(1);
  assign tj_inc    = {1'b0, tj} + TILE_W'(1);
  assign row_share = row_edge && (ti_inc < tr);
  assign col_share = col_edge && (tj_inc < tc);
  assign col_end   = row_counter == POS_W'(sr - SIDE_W'(1));
  assign img_end   = col_end && (col_counter == POS_W'(sc - SIDE_W'(1)));
  assign finish    = ((state == F_RMW0) && !row_sh_q) || (state == F_RMW1);

  // entry holds both column banks of one tile row; a bank reads as zero at or
  // above its fill mark, since tile rows are written in ascending order
  assign bank0 = rd_v0 ? sums_t'(rd_word[NUM_CH*SUM_W-1:0]) : '0;
  assign bank1 = rd_v1 ? sums_t'(rd_word[2*NUM_CH*SUM_W-1:NUM_CH*SUM_W]) : '0;
  assign cur   = sel ? bank1 : bank0;
  assign nxt   = sel ? bank0 : bank1;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      new_cur[c] = cur[c] + SUM_W'(px[c]);
      new_nxt[c] = col_sh_q ? nxt[c] + SUM_W'(px[c]) : nxt[c];
    end
  end

  assign wr_word = sel ? {new_cur, new_nxt} : {new_nxt, new_cur};

  assign h = SIDE_W'(row_st.hi) - SIDE_W'(row_st.lo) + SIDE_W'(1);
  assign w = SIDE_W'(col_st.hi) - SIDE_W'(col_st.lo) + SIDE_W'(1);

  assign job.tile_row = ti;
  assign job.tile_col = tj;
  assign job.sums     = new_cur;
  assign job.count    = CNT_W'(h * w);
  assign job.last     = (ti_inc == tr) && (tj_inc == tc);

  always_comb begin
    state_next = state;
    case (state)
      F_START: state_next = F_WAIT;
      F_WAIT:  if (!row_st.busy && !col_st.busy) state_next = F_IDLE;
      F_IDLE:  if (accept) state_next = F_RMW0;
      F_RMW0:  state_next = row_sh_q ? F_RMW1 : F_IDLE;
      F_RMW1:  state_next = F_IDLE;
      default: state_next = F_START;
    endcase
    if (cfg_wr) state_next = F_START;
  end

  always_comb begin
    pix_stall      = !((state == F_IDLE) && !q_full);
    push           = (state == F_RMW0) && close_q;
    mem_we         = (state == F_RMW0) || (state == F_RMW1);
    wr_addr        = (state == F_RMW1) ? ti + IDX_W'(1) : ti;
    rd_addr        = (state == F_RMW0) ? ti + IDX_W'(1) : ti;
    row_ctl.start  = state == F_START;
    col_ctl.start  = state == F_START;
    row_ctl.reinit = finish && col_end;
    row_ctl.step   = finish && row_sh_q && !col_end;
    col_ctl.reinit = finish && img_end;
    col_ctl.step   = finish && col_end && col_sh_q && !img_end;
  end

  always_comb begin
    fill0_next = fill0;
    fill1_next = fill1;
    if (mem_we && ({1'b0, wr_addr} == fill0)) fill0_next = fill0 + TILE_W'(1);
    if (mem_we && ({1'b0, wr_addr} == fill1)) fill1_next = fill1 + TILE_W'(1);
    // old current bank starts over empty when the next bank takes its place
    if (finish && (img_end || (col_end && col_sh_q && !sel))) fill0_next = '0;
    if (finish && (img_end || (col_end && col_sh_q && sel)))  fill1_next = '0;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      band_mem[wr_addr] <= wr_word;
    end
    rd_word <= band_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_START;
      image_rows <= SIDE_W'(MAX_IMAGE_SIDE);
      image_cols <= SIDE_W'(MAX_IMAGE_SIDE);
      tile_rows  <= TILE_W'(1);
      tile_cols  <= TILE_W'(1);
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        case (cfg_index)
          CFG_IDX_W'(REG_IMAGE_ROWS): image_rows <= cfg_data;
          CFG_IDX_W'(REG_IMAGE_COLS): image_cols <= cfg_data;
          CFG_IDX_W'(REG_TILE_ROWS):  tile_rows  <= cfg_data[TILE_W-1:0];
          CFG_IDX_W'(REG_TILE_COLS):  tile_cols  <= cfg_data[TILE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_v0 <= {1'b0, rd_addr} < fill0;
    rd_v1 <= {1'b0, rd_addr} < fill1;
    if (accept) begin
      px       <= {blue, green, red};
      row_sh_q <= row_share;
      col_sh_q <= col_share;
      close_q  <= row_edge && col_edge;
    end
    if (rst || cfg_wr) begin
      row_counter <= '0;
      col_counter <= '0;
      ti          <= '0;
      tj          <= '0;
      sel         <= 1'b0;
      fill0       <= '0;
      fill1       <= '0;
    end else begin
      fill0 <= fill0_next;
      fill1 <= fill1_next;
      if (finish) begin
        if (img_end) begin
          row_counter <= '0;
          col_counter <= '0;
          ti          <= '0;
          tj          <= '0;
        end else if (col_end) begin
          row_counter <= '0;
          ti          <= '0;
          col_counter <= col_counter + POS_W'(1);
          if (col_sh_q) begin
            // next bank becomes current
            tj  <= tj + IDX_W'(1);
            sel <= ~sel;
          end
        end else begin
          row_counter <= row_counter + POS_W'(1);
          if (row_sh_q) ti <= ti + IDX_W'(1);
        end
      end
    end
  end

endmodule

### rtl/tmd_queue.sv
module tmd_queue import tmd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  tile_job_t job_in,
  input  logic      pop,
  output tile_job_t job_out,
  output logic      full,
  output logic      empty
);

  tile_job_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wp;
  logic [QPTR_W-1:0]  rp;
  logic [QCNT_W-1:0]  count;

  assign full    = count == QCNT_W'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign job_out = entries[rp];

  always_ff @(posedge clk) begin
    if (push) entries[wp] <= job_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + QPTR_W'(1);
      if (pop)  rp <= rp + QPTR_W'(1);
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH)) else $error("tile queue count out of range");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop) else $error("tile pushed into full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("tile popped from empty queue");

endmodule

### rtl/tmd_back.sv
module tmd_back import tmd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  tile_job_t         job,
  output logic              pop,
  output logic              tile_valid,
  input  logic              tile_stall,
  output logic [IDX_W-1:0]  tile_row,
  output logic [IDX_W-1:0]  tile_col,
  output logic [MEAN_W-1:0] mean_red,
  output logic [MEAN_W-1:0] mean_green,
  output logic [MEAN_W-1:0] mean_blue,
  output logic              last_tile
);

  back_state_t state, state_next;

  logic [DIV_CNT_W-1:0]           iter;
  logic [NUM_CH-1:0][CNT_W-1:0]   rem;
  logic [NUM_CH-1:0][MEAN_W-1:0]  quo;
  logic [NUM_CH-1:0][DVD_W-1:0]   dvd;
  logic [NUM_CH-1:0][CNT_W:0]     trial;
  logic [NUM_CH-1:0]              fits;
  logic [CNT_W-1:0]               count;
  logic [IDX_W-1:0]               row_q;
  logic [IDX_W-1:0]               col_q;
  logic                           last_q;
  logic                           load_out;

  // sum*256 + count/2; the quotient fits 16 bits, so the top part starts as remainder
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      dvd[c]   = {1'b0, job.sums[c], {FRAC_W{1'b0}}} + DVD_W'(job.count >> 1);
      trial[c] = {rem[c], quo[c][MEAN_W-1]};
      fits[c]  = trial[c] >= {1'b0, count};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (!empty) state_next = B_DIV;
      B_DIV:  if (iter == DIV_CNT_W'(DIV_STEPS - 1)) state_next = B_DONE;
      B_DONE: if (!tile_valid || !tile_stall) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state == B_IDLE) && !empty;
    load_out = (state == B_DONE) && (!tile_valid || !tile_stall);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      count  <= job.count;
      row_q  <= job.tile_row;
      col_q  <= job.tile_col;
      last_q <= job.last;
      for (int c = 0; c < NUM_CH; c++) begin
        rem[c] <= dvd[c][DVD_W-1:MEAN_W];
        quo[c] <= dvd[c][MEAN_W-1:0];
      end
    end else if (state == B_DIV) begin
      for (int c = 0; c < NUM_CH; c++) begin
        rem[c] <= fits[c] ? CNT_W'(trial[c] - {1'b0, count}) : CNT_W'(trial[c]);
        quo[c] <= {quo[c][MEAN_W-2:0], fits[c]};
      end
    end
    if (load_out) begin
      tile_row   <= row_q;
      tile_col   <= col_q;
      mean_red   <= quo[0];
      mean_green <= quo[1];
      mean_blue  <= quo[2];
      last_tile  <= last_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      iter       <= '0;
      tile_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_DIV) iter <= iter + DIV_CNT_W'(1);
      else                iter <= '0;
      if (load_out)         tile_valid <= 1'b1;
      else if (!tile_stall) tile_valid <= 1'b0;
    end
  end

  a_out_from_div: assert property (@(posedge clk) disable iff (rst)
    $rose(tile_valid) |-> $past(state) == B_DONE)
    else $error("result shown without finished division");

endmodule

### rtl/tile_mean_downsampler_unit.sv
// Area-average downsampler: RGB pixels stream in column-major order, one beat per
// pixel, and one beat per finished tile comes out with the tile's channel means
// (8 fraction bits, ties rounded up) in column-major tile order. The front end takes
// a pixel only when idle, then steps through RMW0, and RMW1 too when the pixel lies on
// a tile-row boundary, since each tile row touched is a read-modify-write of the
// band-sum memory (one read and one write port). A finished tile is then divided in
// the back end (one quotient bit a cycle); a four-entry queue decouples the two, and
// the pixel side stalls while the queue is full or the front end is busy. After reset
// and after every register write the boundary setup runs, with pixels stalled. Any
// register write restarts the image.
module tile_mean_downsampler_unit import tmd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 pix_valid,
  output logic                 pix_stall,
  input  logic [PIX_W-1:0]     red,
  input  logic [PIX_W-1:0]     green,
  input  logic [PIX_W-1:0]     blue,
  output logic                 tile_valid,
  input  logic                 tile_stall,
  output logic [IDX_W-1:0]     tile_row,
  output logic [IDX_W-1:0]     tile_col,
  output logic [MEAN_W-1:0]    mean_red,
  output logic [MEAN_W-1:0]    mean_green,
  output logic [MEAN_W-1:0]    mean_blue,
  output logic                 last_tile
);

  tile_job_t job_in;
  tile_job_t job_out;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_empty;

  assign cfg_ready = 1'b1;

  tmd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .q_full    (q_full),
    .push      (push),
    .job       (job_in)
  );

  tmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .job_in  (job_in),
    .pop     (pop),
    .job_out (job_out),
    .full    (q_full),
    .empty   (q_empty)
  );

  tmd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (q_empty),
    .job        (job_out),
    .pop        (pop),
    .tile_valid (tile_valid),
    .tile_stall (tile_stall),
    .tile_row   (tile_row),
    .tile_col   (tile_col),
    .mean_red   (mean_red),
    .mean_green (mean_green),
    .mean_blue  (mean_blue),
    .last_tile  (last_tile)
  );

endmodule

### tb/tile_mean_downsampler_unit_tb.sv
`timescale 1ns / 1ps

module tile_mean_downsampler_unit_tb;
  import tmd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 120;

  typedef struct {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  typedef struct {
    logic [IDX_W-1:0]  tile_row;
    logic [IDX_W-1:0]  tile_col;
    logic [MEAN_W-1:0] mean_red;
    logic [MEAN_W-1:0] mean_green;
    logic [MEAN_W-1:0] mean_blue;
    logic              last_tile;
  } tile_mean_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 pix_valid;
  logic                 pix_stall;
  logic [PIX_W-1:0]     red;
  logic [PIX_W-1:0]     green;
  logic [PIX_W-1:0]     blue;
  logic                 tile_valid;
  logic                 tile_stall;
  logic [IDX_W-1:0]     tile_row;
  logic [IDX_W-1:0]     tile_col;
  logic [MEAN_W-1:0]    mean_red;
  logic [MEAN_W-1:0]    mean_green;
  logic [MEAN_W-1:0]    mean_blue;
  logic                 last_tile;

  tile_mean_downsampler_unit i_dut (.*);

  pixel_t     pixel_q[$];
  tile_mean_t tile_mean_q[$];
  int         err_cnt;
  int         cycle_cnt;
  int         send_idle_pct;
  int         recv_idle_pct;
  bit         hold_pixels;

  // shadow of the block
  logic [SIDE_W-1:0] rows_reg, cols_reg;
  logic [TILE_W-1:0] trows_reg, tcols_reg;
  int unsigned       row_pos, col_pos, tile_r, tile_c, row_edge_at, col_edge_at;
  longint unsigned   band_cur[MAX_TILES_SIDE][NUM_CH];
  longint unsigned   band_nxt[MAX_TILES_SIDE][NUM_CH];

  function automatic int unsigned eff_side(int unsigned v);
    if (v < 2) return 2;
    if (v > MAX_IMAGE_SIDE) return MAX_IMAGE_SIDE;
    return v;
  endfunction

  function automatic int unsigned eff_tiles(int unsigned t, int unsigned s);
    int unsigned hi;
    hi = (s - 1 > MAX_TILES_SIDE) ? MAX_TILES_SIDE : s - 1;
    if (t < 1) return 1;
    if (t > hi) return hi;
    return t;
  endfunction

  // exact boundary position, half to even
  function automatic int unsigned edge_pos(int unsigned i, int unsigned s, int unsigned t);
    longint unsigned num, q, r;
    num = longint'(t) + longint'(i) * longint'(s - 1);
    q = num / t;
    r = num % t;
    if (2 * r > t || (2 * r == t && q[0])) q++;
    return int'(q - 1);
  endfunction

  task automatic restart_image();
    int unsigned sr, sc;
    sr = eff_side(rows_reg);
    sc = eff_side(cols_reg);
    row_pos = 0;
    col_pos = 0;
    tile_r = 0;
    tile_c = 0;
    row_edge_at = edge_pos(1, sr, eff_tiles(trows_reg, sr));
    col_edge_at = edge_pos(1, sc, eff_tiles(tcols_reg, sc));
    foreach (band_cur[i, k]) begin
      band_cur[i][k] = 0;
      band_nxt[i][k] = 0;
    end
  endtask

  task automatic predict_pixel(pixel_t p);
    int unsigned     sr, sc, tr, tc, ti, tj;
    bit              row_hit, col_hit, row_share, col_share;
    longint unsigned px[NUM_CH];
    longint unsigned cnt, m[NUM_CH];
    tile_mean_t      e;
    sr = eff_side(rows_reg);
    sc = eff_side(cols_reg);
    tr = eff_tiles(trows_reg, sr);
    tc = eff_tiles(tcols_reg, sc);
    ti = tile_r;
    tj = tile_c;
    row_hit = (row_pos == row_edge_at);
    col_hit = (col_pos == col_edge_at);
    row_share = row_hit && (ti + 1 < tr);
    col_share = col_hit && (tj + 1 < tc);
    px[0] = p.red;
    px[1] = p.green;
    px[2] = p.blue;
    for (int k = 0; k < NUM_CH; k++) begin
      band_cur[ti][k] += px[k];
      if (row_share) band_cur[ti + 1][k] += px[k];
      if (col_share) begin
        band_nxt[ti][k] += px[k];
        if (row_share) band_nxt[ti + 1][k] += px[k];
      end
    end
    if (row_hit && col_hit) begin
      cnt = longint'(row_edge_at - edge_pos(ti, sr, tr) + 1)
          * longint'(col_edge_at - edge_pos(tj, sc, tc) + 1);
      for (int k = 0; k < NUM_CH; k++) m[k] = (band_cur[ti][k] * 256 + cnt / 2) / cnt;
      e.tile_row = ti[IDX_W-1:0];
      e.tile_col = tj[IDX_W-1:0];
      e.mean_red = m[0][MEAN_W-1:0];
      e.mean_green = m[1][MEAN_W-1:0];
      e.mean_blue = m[2][MEAN_W-1:0];
      e.last_tile = (ti + 1 == tr) && (tj + 1 == tc);
      tile_mean_q.push_back(e);
    end
    if (row_share) begin
      tile_r = ti + 1;
      row_edge_at = edge_pos(ti + 2, sr, tr);
    end
    row_pos++;
    if (row_pos >= sr) begin
      row_pos = 0;
      tile_r = 0;
      row_edge_at = edge_pos(1, sr, tr);
      if (col_share) begin
        band_cur = band_nxt;
        foreach (band_nxt[i, k]) band_nxt[i][k] = 0;
        tile_c = tj + 1;
        col_edge_at = edge_pos(tj + 2, sc, tc);
      end
      col_pos++;
      if (col_pos >= sc) restart_image();
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tile_mean_downsampler_unit_tb: done, errors");
      $finish;
    end
  end

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else begin
      if (pix_valid && !pix_stall) begin
        predict_pixel(pixel_q.pop_front());
      end
      if (pix_valid && pix_stall) begin
        // hold the beat
      end else if (pixel_q.size() > 0 && !hold_pixels &&
                   $urandom_range(99) >= send_idle_pct) begin
        pix_valid <= 1'b1;
        red <= pixel_q[0].red;
        green <= pixel_q[0].green;
        blue <= pixel_q[0].blue;
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // tile monitor
  always @(posedge clk) begin
    tile_mean_t e;
    if (rst) begin
      tile_stall <= 1'b0;
    end else begin
      if (tile_valid && !tile_stall) begin
        if (tile_mean_q.size() == 0) begin
          report("unexpected tile beat, row", tile_row, 0);
        end else begin
          e = tile_mean_q.pop_front();
          if (tile_row !== e.tile_row) report("tile_row", tile_row, e.tile_row);
          if (tile_col !== e.tile_col) report("tile_col", tile_col, e.tile_col);
          if (mean_red !== e.mean_red) report("mean_red", mean_red, e.mean_red);
          if (mean_green !== e.mean_green) report("mean_green", mean_green, e.mean_green);
          if (mean_blue !== e.mean_blue) report("mean_blue", mean_blue, e.mean_blue);
          if (last_tile !== e.last_tile) report("last_tile", last_tile, e.last_tile);
        end
      end
      tile_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_IDX_W'(REG_IMAGE_ROWS): rows_reg = val;
      CFG_IDX_W'(REG_IMAGE_COLS): cols_reg = val;
      CFG_IDX_W'(REG_TILE_ROWS):  trows_reg = val[TILE_W-1:0];
      CFG_IDX_W'(REG_TILE_COLS):  tcols_reg = val[TILE_W-1:0];
      default: ;
    endcase
    restart_image();
    cfg_valid <= 1'b0;
  endtask

  // wait for every pixel and tile beat, then let the divider settle
  task automatic drain();
    @(negedge clk);
    while (pixel_q.size() > 0 || tile_mean_q.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic setup(int r, int c, int tr, int tc);
    drain();
    write_reg(REG_IMAGE_ROWS, CFG_DAT_W'(r));
    write_reg(REG_IMAGE_COLS, CFG_DAT_W'(c));
    write_reg(REG_TILE_ROWS, CFG_DAT_W'(tr));
    write_reg(REG_TILE_COLS, CFG_DAT_W'(tc));
    @(negedge clk);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.red = $urandom;
    p.green = $urandom;
    p.blue = $urandom;
    if ($urandom_range(7) == 0) p.red = $urandom_range(1) ? 8'hff : 8'h00;
    if ($urandom_range(7) == 0) p.blue = $urandom_range(1) ? 8'hff : 8'h00;
    return p;
  endfunction

  task automatic feed(int n, int mode);
    pixel_t p;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: p = '{8'h00, 8'h00, 8'h00};
        1: p = '{8'hff, 8'hff, 8'hff};
        default: p = rand_pixel();
      endcase
      pixel_q.push_back(p);
    end
  endtask

  initial begin
    int sent, r, c, n;
    err_cnt = 0;
    cycle_cnt = 0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_valid = 1'b0;
    red = '0;
    green = '0;
    blue = '0;
    tile_stall = 1'b0;
    hold_pixels = 1'b0;
    send_idle_pct = 6;
    recv_idle_pct = 69;
    rows_reg = MAX_IMAGE_SIDE;
    cols_reg = MAX_IMAGE_SIDE;
    trows_reg = 1;
    tcols_reg = 1;
    restart_image();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // a few pixels into the reset-size image, then restart by a write off the map
    feed(6, 2);
    drain();
    write_reg(8'hff, 13'h1fff);
    // smallest image, all dark then all bright
    setup(2, 2, 1, 1);
    feed(4, 0);
    feed(4, 1);
    // out-of-range sides and tile counts clamp
    setup(0, 1, 0, 511);
    feed(4, 2);
    setup(5, 4, 3, 2);
    feed(20, 2);
    // partial image, then a restart
    setup(3, 3, 2, 2);
    feed(5, 2);
    setup(8191, 2, 300, 1);
    feed(3, 2);
    // most tile rows, tile index at its top
    setup(257, 2, 256, 1);
    feed(514, 2);

    // sender slow and receiver quick, then neither idles
    send_idle_pct = 69;
    recv_idle_pct = 6;
    sent = 0;
    while (sent < 60) begin
      if (sent >= 30) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      r = $urandom_range(2, 8);
      c = $urandom_range(2, 6);
      setup(r, c, $urandom_range(0, r + 1), $urandom_range(0, c + 1));
      n = r * c;
      if ($urandom_range(7) == 0) n = $urandom_range(1, n - 1);
      else if ($urandom_range(3) == 0) n = 2 * n;
      feed(n, 2);
      sent += n;
      if (sent >= 30 && sent - n < 30) begin
        // sender waits for the block to run dry
        @(negedge clk);
        hold_pixels = 1'b1;
        while (tile_mean_q.size() > 0) @(negedge clk);
        hold_pixels = 1'b0;
      end
    end

    drain();
    if (err_cnt == 0) begin
      $display("tile_mean_downsampler_unit_tb: done, clean");
    end else begin
      $display("tile_mean_downsampler_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
rtl/tmd_pkg.sv
rtl/tmd_axis.sv
rtl/tmd_front.sv
rtl/tmd_queue.sv
rtl/tmd_back.sv
rtl/tile_mean_downsampler_unit.sv
tb/tile_mean_downsampler_unit_tb.sv
